// ===== rtl/tmrf_pkg.sv =====
// Shared types and constants for the masked rectangle fill tile map.
// No dependencies; imported by every module of the block.
`default_nettype none

package tmrf_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int COORD_W = 7;
    localparam int TILE_W  = 8;

    typedef logic [1:0]         t_mode;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [TILE_W-1:0]  t_tile;

    localparam t_mode MODE_WRITE = 2'd0;
    localparam t_mode MODE_READ  = 2'd1;
    localparam t_mode MODE_FILL  = 2'd2;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam t_coord MAP_SIZE_RST = 7'd64;
    localparam t_tile  TILE_OOR     = 8'hFF;
    localparam t_tile  TILE_ZERO    = 8'h00;

endpackage

`default_nettype wire

// ===== rtl/tmrf_ram.sv =====
// Tile store: one write port and one registered read port.
// Depends on tmrf_pkg for the tile type.
`default_nettype none

module tmrf_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire  [AW-1:0]         i_waddr,
    input  tmrf_pkg::t_tile       i_wdata,
    input  wire                   i_re,
    input  wire  [AW-1:0]         i_raddr,
    output tmrf_pkg::t_tile       o_rdata
);
    import tmrf_pkg::*;

    t_tile mem [DEPTH];
    t_tile r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tmrf_agu.sv =====
// Address unit: registered row-major index width * row + col.
// Depends on tmrf_pkg for the coordinate type.
`default_nettype none

module tmrf_agu #(
    parameter int AW = 12
) (
    input  wire                   i_clk,
    input  tmrf_pkg::t_coord      i_width,
    input  tmrf_pkg::t_coord      i_col,
    input  tmrf_pkg::t_coord      i_row,
    output logic [AW-1:0]         o_addr
);
    import tmrf_pkg::*;

    logic [2*COORD_W-1:0] w_prod;
    logic [2*COORD_W:0]   w_sum;
    logic [AW-1:0]        r_addr;

    assign w_prod = (2*COORD_W)'(i_width) * (2*COORD_W)'(i_row);
    assign w_sum  = {1'b0, w_prod} + (2*COORD_W+1)'(i_col);

    always_ff @(posedge i_clk) begin
        r_addr <= AW'(w_sum);
    end

    assign o_addr = r_addr;

endmodule

`default_nettype wire

// ===== rtl/tile_map_masked_rect_fill_core.sv =====
// From input transfer to result valid, a read or write steps through S_ADDR, S_ACCESS
// and S_DONE; a fill steps through S_ADDR, S_FRD and S_FWR for each visited cell, then
// S_DONE; an empty rectangle or the unused mode goes straight to S_DONE. One item at
// a time; the next input is taken once the result is registered, later while the
// result register is full. Reset: map size 64x64, then a clearing pass zeroes all
// MAX_WIDTH*MAX_HEIGHT tiles; no input transfer is taken meanwhile, config writes are.
`default_nettype none

module tile_map_masked_rect_fill_core #(
    parameter int MAX_WIDTH  = tmrf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tmrf_pkg::MAX_HEIGHT_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire                   i_cfg_index,
    input  wire  [6:0]            i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  tmrf_pkg::t_mode       i_mode,
    input  wire  signed [7:0]     i_pos_x,
    input  wire  signed [7:0]     i_pos_y,
    input  wire  [7:0]            i_rect_w,
    input  wire  [7:0]            i_rect_h,
    input  wire  signed [7:0]     i_new_value,
    input  wire  signed [7:0]     i_match_value,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic signed [7:0]     o_tile_out,
    output logic                  o_in_range
);
    import tmrf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_ACCESS, S_FRD, S_FWR, S_DONE
    } t_state;

    t_state  r_state;
    logic [AW-1:0] r_clr;
    t_coord  r_map_w, r_map_h;
    t_mode   r_mode;
    t_coord  r_cx, r_cy, r_x0, r_x1, r_y1;
    t_tile   r_val, r_match;
    logic    r_inr;
    logic    r_out_valid;
    t_tile   r_tile_out;
    logic    r_in_range;

    t_coord  w_eff_w, w_eff_h;
    logic    w_accept, w_inside;
    t_coord  w_x0, w_y0;
    logic signed [9:0] w_x_end, w_y_end, w_x_lim, w_y_lim;
    logic    w_empty;
    logic [AW-1:0] w_addr;
    logic    w_we, w_re, w_match_hit, w_row_end, w_last;
    logic [AW-1:0] w_waddr;
    t_tile   w_wdata, w_rdata;

    assign w_eff_w = (int'(r_map_w) > MAX_WIDTH)  ? COORD_W'(MAX_WIDTH)  : r_map_w;
    assign w_eff_h = (int'(r_map_h) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : r_map_h;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_inside = !i_pos_x[7] && (i_pos_x[6:0] < w_eff_w)
                   && !i_pos_y[7] && (i_pos_y[6:0] < w_eff_h);

    assign w_x0    = i_pos_x[7] ? '0 : i_pos_x[6:0];
    assign w_y0    = i_pos_y[7] ? '0 : i_pos_y[6:0];
    assign w_x_end = {{2{i_pos_x[7]}}, i_pos_x} + $signed({2'b00, i_rect_w});
    assign w_y_end = {{2{i_pos_y[7]}}, i_pos_y} + $signed({2'b00, i_rect_h});
    assign w_x_lim = (w_x_end > $signed({3'b000, w_eff_w})) ? $signed({3'b000, w_eff_w})
                                                             : w_x_end;
    assign w_y_lim = (w_y_end > $signed({3'b000, w_eff_h})) ? $signed({3'b000, w_eff_h})
                                                             : w_y_end;
    assign w_empty = (w_x_lim <= $signed({3'b000, w_x0}))
                  || (w_y_lim <= $signed({3'b000, w_y0}));

    assign w_match_hit = (w_rdata == r_match);
    assign w_row_end   = ((r_cx + 7'd1) == r_x1);
    assign w_last      = w_row_end && ((r_cy + 7'd1) == r_y1);

    assign w_we = (r_state == S_CLEAR)
               || ((r_state == S_ACCESS) && (r_mode == MODE_WRITE) && r_inr)
               || ((r_state == S_FWR) && w_match_hit);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : w_addr;
    assign w_wdata = (r_state == S_CLEAR) ? TILE_ZERO : r_val;
    assign w_re    = (r_state == S_ACCESS) || (r_state == S_FRD);

    tmrf_agu #(.AW(AW)) u_agu (
        .i_clk   (i_clk),
        .i_width (w_eff_w),
        .i_col   (r_cx),
        .i_row   (r_cy),
        .o_addr  (w_addr)
    );

    tmrf_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_map_w     <= MAP_SIZE_RST;
            r_map_h     <= MAP_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                    REG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode  <= i_mode;
                        r_val   <= i_new_value;
                        r_match <= i_match_value;
                        r_x0    <= w_x0;
                        r_x1    <= w_x_lim[6:0];
                        r_y1    <= w_y_lim[6:0];
                        if (i_mode == MODE_FILL) begin
                            r_cx    <= w_x0;
                            r_cy    <= w_y0;
                            r_inr   <= 1'b0;
                            r_state <= w_empty ? S_DONE : S_ADDR;
                        end else if (i_mode == MODE_WRITE || i_mode == MODE_READ) begin
                            r_cx    <= i_pos_x[6:0];
                            r_cy    <= i_pos_y[6:0];
                            r_inr   <= w_inside;
                            r_state <= S_ADDR;
                        end else begin
                            r_inr   <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ADDR: begin
                    r_state <= (r_mode == MODE_FILL) ? S_FRD : S_ACCESS;
                end
                S_ACCESS: begin
                    r_state <= S_DONE;
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    if (w_row_end) begin
                        r_cx <= r_x0;
                        r_cy <= r_cy + 7'd1;
                    end else begin
                        r_cx <= r_cx + 7'd1;
                    end
                    r_state <= w_last ? S_DONE : S_ADDR;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_in_range  <= r_inr;
                        if (r_mode == MODE_READ) begin
                            r_tile_out <= r_inr ? w_rdata : TILE_OOR;
                        end else begin
                            r_tile_out <= TILE_ZERO;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tile_out  = r_tile_out;
    assign o_in_range  = r_in_range;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion state");

    a_fill_write_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FWR) && w_we) |-> (w_rdata == r_match))
        else $error("fill wrote a tile that did not match");

    a_fill_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |-> ((r_cx < r_x1) && (r_cy < r_y1)
                                && (r_x1 <= w_eff_w) && (r_y1 <= w_eff_h)))
        else $error("fill cell outside rectangle or map");

    a_no_read_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWR) |=> (r_state == S_ADDR || r_state == S_DONE))
        else $error("fill sequencer left its loop");
`endif

endmodule

`default_nettype wire
